/* hw/rtl/srrw_pkg.sv */
// Shared types and constants for the selective-repeat receive window.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package srrw_pkg;

    localparam int WINDOW_FRAMES_DEFAULT = 8;
    localparam int QUEUE_DEPTH           = 2;
    localparam int CFG_INDEX_W           = 4;

    localparam logic [15:0] FRAMES_PER_BLOCK_RESET = 16'd64;
    localparam logic [15:0] FRAME_DATA_BYTES_RESET = 16'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAMES_PER_BLOCK = 4'd0,
        REG_FRAME_DATA_BYTES = 4'd1
    } cfg_reg_t;

    // classified frame word handed from front to back
    typedef struct packed {
        logic [15:0] seq;
        logic        bad;
        logic        last;
        logic [15:0] plen;
        logic [31:0] offset;
    } frame_t;

    typedef struct packed {
        logic        ack_good;
        logic [15:0] ack_seq;
        logic        store_payload;
        logic [31:0] store_offset;
        logic        block_complete;
        logic [31:0] block_bytes;
        logic        transfer_done;
        logic [16:0] expected_seq;
    } result_t;

endpackage

/* hw/rtl/srrw_front.sv */
// Front stage: accepts frame headers and registers them with their byte offset.
// Depends on srrw_pkg.
`timescale 1ns / 1ps

module srrw_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      seq_number,
    input  logic             bad_checksum,
    input  logic             last_frame,
    input  logic [15:0]      payload_len,
    input  logic [15:0]      frame_data_bytes,
    output logic             push_valid,
    input  logic             push_ready,
    output srrw_pkg::frame_t push_frame
);
    import srrw_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;
    logic   accept;

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_frame = frame_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg.seq    <= seq_number;
            frame_reg.bad    <= bad_checksum;
            frame_reg.last   <= last_frame;
            frame_reg.plen   <= payload_len;
            frame_reg.offset <= seq_number * frame_data_bytes;
        end
    end

endmodule

/* hw/rtl/srrw_queue.sv */
// Short queue of classified frame words between front and back.
// Depends on srrw_pkg.
`timescale 1ns / 1ps

module srrw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  srrw_pkg::frame_t push_frame,
    output logic             pop_valid,
    input  logic             pop_ready,
    output srrw_pkg::frame_t pop_frame
);
    import srrw_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg < COUNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_frame  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");

endmodule

/* hw/rtl/srrw_back.sv */
// Back stage: window state, slide, block completion and the result register.
// Depends on srrw_pkg.
`timescale 1ns / 1ps

module srrw_back #(
    parameter int WINDOW_FRAMES = srrw_pkg::WINDOW_FRAMES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       frames_per_block,
    input  logic [15:0]       frame_data_bytes,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  srrw_pkg::frame_t  pop_frame,
    output logic              out_valid,
    input  logic              out_ready,
    output srrw_pkg::result_t result
);
    import srrw_pkg::*;

    localparam int STEP_W = $clog2(WINDOW_FRAMES + 1);

    logic [WINDOW_FRAMES-1:0] map_reg;
    logic [WINDOW_FRAMES-1:0] map_next;
    logic [16:0]              ne_reg;
    logic [16:0]              ne_next;
    logic [16:0]              limit_reg;
    logic [16:0]              limit_next;
    logic                     end_seen_reg;
    logic                     end_seen_next;
    logic [31:0]              end_bytes_reg;
    logic [31:0]              end_bytes_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    result_t                  result_reg;
    result_t                  result_next;

    logic                     pop;
    logic [WINDOW_FRAMES-1:0] one_w;
    logic [STEP_W-1:0]        step;
    logic [WINDOW_FRAMES-1:0] map_slide;
    logic [16:0]              diff;
    logic [WINDOW_FRAMES-1:0] ahead_bit;
    logic                     in_win;
    logic                     in_order;
    logic                     ahead_new;
    logic                     last_hit;
    logic [WINDOW_FRAMES-1:0] map_a;
    logic [16:0]              ne_a;
    logic [16:0]              limit_a;
    logic                     end_seen_a;
    logic [31:0]              end_bytes_a;
    logic                     complete;
    logic                     done;
    logic [32:0]              limit_prod;

    assign pop       = pop_valid && pop_ready;
    assign pop_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign one_w     = WINDOW_FRAMES'(1);

    // advance past the in-order frame and the marked run behind it
    always_comb
    begin
        step = STEP_W'(WINDOW_FRAMES);
        for (int i = WINDOW_FRAMES - 1; i >= 1; i--)
        begin
            if (!map_reg[i])
            begin
                step = STEP_W'(i);
            end
        end
    end

    assign map_slide  = map_reg >> step;
    assign diff       = {1'b0, pop_frame.seq} - ne_reg;
    assign ahead_bit  = one_w << diff;
    assign limit_prod = limit_reg * {1'b0, frame_data_bytes};

    assign in_win    = !pop_frame.bad &&
                       ({2'b00, pop_frame.seq} < ({1'b0, ne_reg} + 18'(WINDOW_FRAMES)));
    assign in_order  = in_win && ({1'b0, pop_frame.seq} == ne_reg);
    assign ahead_new = in_win && ({1'b0, pop_frame.seq} > ne_reg) &&
                       ((map_reg & ahead_bit) == '0);
    assign last_hit  = in_win && pop_frame.last;

    always_comb
    begin
        map_a       = map_reg;
        ne_a        = ne_reg;
        limit_a     = limit_reg;
        end_seen_a  = end_seen_reg;
        end_bytes_a = end_bytes_reg;
        if (in_order)
        begin
            map_a = map_slide;
            ne_a  = ne_reg + 17'(step);
        end
        else if (ahead_new)
        begin
            map_a = map_reg | ahead_bit;
        end
        if (last_hit)
        begin
            limit_a     = {1'b0, pop_frame.seq} + 17'd1;
            end_seen_a  = 1'b1;
            end_bytes_a = pop_frame.offset + {16'd0, pop_frame.plen};
        end
    end

    assign complete = ne_a >= limit_a;
    assign done     = complete && end_seen_a;

    always_comb
    begin
        map_next       = map_reg;
        ne_next        = ne_reg;
        limit_next     = limit_reg;
        end_seen_next  = end_seen_reg;
        end_bytes_next = end_bytes_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next             = 1'b1;
            result_next.ack_good       = !pop_frame.bad;
            result_next.ack_seq        = pop_frame.seq;
            result_next.store_payload  = in_order || ahead_new;
            result_next.store_offset   = (in_order || ahead_new) ? pop_frame.offset : 32'd0;
            result_next.block_complete = complete;
            result_next.block_bytes    = !complete ? 32'd0 :
                                         end_seen_a ? end_bytes_a : limit_prod[31:0];
            result_next.transfer_done  = done;
            result_next.expected_seq   = complete ? 17'd0 : ne_a;
            if (complete)
            begin
                map_next       = '0;
                ne_next        = '0;
                limit_next     = {1'b0, frames_per_block};
                end_seen_next  = done ? 1'b0 : end_seen_a;
                end_bytes_next = done ? 32'd0 : end_bytes_a;
            end
            else
            begin
                map_next       = map_a;
                ne_next        = ne_a;
                limit_next     = limit_a;
                end_seen_next  = end_seen_a;
                end_bytes_next = end_bytes_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            ne_reg        <= '0;
            limit_reg     <= {1'b0, FRAMES_PER_BLOCK_RESET};
            end_seen_reg  <= 1'b0;
            end_bytes_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            map_reg       <= map_next;
            ne_reg        <= ne_next;
            limit_reg     <= limit_next;
            end_seen_reg  <= end_seen_next;
            end_bytes_reg <= end_bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !map_reg[0])
        else $error("window mark set on the expected frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.block_complete) |-> (ne_reg == 17'd0))
        else $error("window not restarted after block completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.transfer_done) |->
        (result_reg.block_complete && !end_seen_reg && (end_bytes_reg == 32'd0)))
        else $error("transfer end state not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(result_reg)))
        else $error("held result changed");

endmodule

/* hw/rtl/selective_repeat_receive_window.sv */
// Selective-repeat receive window: top level with configuration registers.
// Depends on srrw_pkg, srrw_front, srrw_queue, srrw_back.
//
// Takes one frame header per clock while in_ready is high and returns one
// acknowledge word per header, in order. A header is registered with its
// byte offset in the front stage, passes through a two-word queue and is
// applied to the window state in the back stage, whose output register
// holds the result. Throughput is one header per cycle when neither side
// stalls; the window update and block completion check in the back stage
// are combinational. Both sides stall independently.
// Configuration writes are always accepted and are meant for idle periods;
// frames_per_block applies from the next block restart.
`timescale 1ns / 1ps

module selective_repeat_receive_window #(
    parameter int WINDOW_FRAMES = srrw_pkg::WINDOW_FRAMES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srrw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [15:0]                      seq_number,
    input  logic                             bad_checksum,
    input  logic                             last_frame,
    input  logic [15:0]                      payload_len,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             ack_good,
    output logic [15:0]                      ack_seq,
    output logic                             store_payload,
    output logic [31:0]                      store_offset,
    output logic                             block_complete,
    output logic [31:0]                      block_bytes,
    output logic                             transfer_done,
    output logic [16:0]                      expected_seq
);
    import srrw_pkg::*;

    logic [15:0] fpb_reg;
    logic [15:0] fpb_next;
    logic [15:0] fdb_reg;
    logic [15:0] fdb_next;
    logic        push_valid;
    logic        push_ready;
    frame_t      push_frame;
    logic        pop_valid;
    logic        pop_ready;
    frame_t      pop_frame;
    result_t     result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        fpb_next = fpb_reg;
        fdb_next = fdb_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAMES_PER_BLOCK: fpb_next = cfg_data;
                REG_FRAME_DATA_BYTES: fdb_next = cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpb_reg <= FRAMES_PER_BLOCK_RESET;
            fdb_reg <= FRAME_DATA_BYTES_RESET;
        end
        else
        begin
            fpb_reg <= fpb_next;
            fdb_reg <= fdb_next;
        end
    end

    srrw_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .seq_number       (seq_number),
        .bad_checksum     (bad_checksum),
        .last_frame       (last_frame),
        .payload_len      (payload_len),
        .frame_data_bytes (fdb_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_frame       (push_frame)
    );

    srrw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    srrw_back #(
        .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .frames_per_block (fpb_reg),
        .frame_data_bytes (fdb_reg),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_frame        (pop_frame),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result           (result)
    );

    assign ack_good       = result.ack_good;
    assign ack_seq        = result.ack_seq;
    assign store_payload  = result.store_payload;
    assign store_offset   = result.store_offset;
    assign block_complete = result.block_complete;
    assign block_bytes    = result.block_bytes;
    assign transfer_done  = result.transfer_done;
    assign expected_seq   = result.expected_seq;

endmodule
